// ===== hw/rtl/khtd_pkg.sv =====
// ----------------------------------------------------------------------------
// khtd_pkg
// Shared constants and controller/datapath signal groups for the k-ary heap
// tree distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package khtd_pkg;

  localparam int NODE_BITS   = 48;
  localparam int DIST_BITS   = 48;
  localparam int BRANCH_BITS = 32;
  localparam int CNT_BITS    = $clog2(NODE_BITS);

  localparam logic [BRANCH_BITS-1:0] BRANCH_RESET = BRANCH_BITS'(2);

  typedef struct packed {
    logic load;     // capture a new pair of nodes
    logic start;    // pick the larger node and seed the divider
    logic step;     // one restoring division bit
    logic update;   // replace the larger node by its parent
    logic finish;   // move the result into the output register
  } ctl_cmd_t;

  typedef struct packed {
    logic path_mode;  // branching of 0 or 1: tree is a path
    logic same;       // both nodes meet
    logic div_last;   // last division bit in flight
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/khtd_in_if.sv =====
// ----------------------------------------------------------------------------
// khtd_in_if
// Input channel: a pair of node numbers with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface khtd_in_if;
  logic                           valid;
  logic                           ready;
  logic [khtd_pkg::NODE_BITS-1:0] node_a;
  logic [khtd_pkg::NODE_BITS-1:0] node_b;

  modport source (output valid, output node_a, output node_b, input ready);
  modport sink   (input valid, input node_a, input node_b, output ready);
  modport mon    (input valid, input node_a, input node_b, input ready);
endinterface

`default_nettype wire

// ===== hw/rtl/khtd_out_if.sv =====
// ----------------------------------------------------------------------------
// khtd_out_if
// Result channel: path length with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface khtd_out_if;
  logic                           valid;
  logic                           ready;
  logic [khtd_pkg::DIST_BITS-1:0] distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
  modport mon    (input valid, input distance, input ready);
endinterface

`default_nettype wire

// ===== hw/rtl/khtd_dp.sv =====
// ----------------------------------------------------------------------------
// khtd_dp
// Datapath: node registers, bit-serial parent divider, step counter and
// output payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module khtd_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [khtd_pkg::BRANCH_BITS-1:0] cfg_wdata,
  input  wire logic [khtd_pkg::NODE_BITS-1:0]   node_a,
  input  wire logic [khtd_pkg::NODE_BITS-1:0]   node_b,
  input  wire khtd_pkg::ctl_cmd_t               cmd,
  output khtd_pkg::dp_stat_t                    stat,
  output logic [khtd_pkg::DIST_BITS-1:0]        distance
);

  logic [khtd_pkg::BRANCH_BITS-1:0] k_r, k_nxt;
  logic [khtd_pkg::NODE_BITS-1:0]   a_r, a_nxt;
  logic [khtd_pkg::NODE_BITS-1:0]   b_r, b_nxt;
  logic [khtd_pkg::DIST_BITS-1:0]   dist_r, dist_nxt;
  logic [khtd_pkg::DIST_BITS-1:0]   dout_r, dout_nxt;
  logic [khtd_pkg::NODE_BITS-1:0]   x_r, x_nxt;      // dividend in, quotient out
  logic [khtd_pkg::BRANCH_BITS-1:0] rem_r, rem_nxt;
  logic [khtd_pkg::CNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic                             sel_a_r, sel_a_nxt;

  logic                             a_gt_b;
  logic [khtd_pkg::NODE_BITS-1:0]   big;
  logic [khtd_pkg::NODE_BITS-1:0]   absdiff;
  logic [khtd_pkg::BRANCH_BITS:0]   trial;
  logic [khtd_pkg::BRANCH_BITS:0]   trial_sub;
  logic [khtd_pkg::NODE_BITS-1:0]   parent;

  assign a_gt_b  = a_r > b_r;
  assign big     = a_gt_b ? a_r : b_r;
  assign absdiff = (a_r >= b_r) ? (a_r - b_r) : (b_r - a_r);
  assign trial   = {rem_r, x_r[khtd_pkg::NODE_BITS-1]};
  assign trial_sub = trial - {1'b0, k_r};
  assign parent  = x_r + khtd_pkg::NODE_BITS'(1);

  assign stat.path_mode = k_r <= khtd_pkg::BRANCH_BITS'(1);
  assign stat.same      = a_r == b_r;
  assign stat.div_last  = cnt_r == khtd_pkg::CNT_BITS'(khtd_pkg::NODE_BITS - 1);
  assign distance       = dout_r;

  always_comb begin
    k_nxt     = k_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    dist_nxt  = dist_r;
    dout_nxt  = dout_r;
    x_nxt     = x_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    sel_a_nxt = sel_a_r;
    if (cfg_we) begin
      k_nxt = cfg_wdata;
    end
    if (cmd.load) begin
      // node zero stands for the root
      a_nxt    = (node_a == '0) ? khtd_pkg::NODE_BITS'(1) : node_a;
      b_nxt    = (node_b == '0) ? khtd_pkg::NODE_BITS'(1) : node_b;
      dist_nxt = '0;
    end
    if (cmd.start) begin
      sel_a_nxt = a_gt_b;
      x_nxt     = big - khtd_pkg::NODE_BITS'(2);
      rem_nxt   = '0;
      cnt_nxt   = '0;
    end
    if (cmd.step) begin
      if (!trial_sub[khtd_pkg::BRANCH_BITS]) begin
        rem_nxt = trial_sub[khtd_pkg::BRANCH_BITS-1:0];
        x_nxt   = {x_r[khtd_pkg::NODE_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[khtd_pkg::BRANCH_BITS-1:0];
        x_nxt   = {x_r[khtd_pkg::NODE_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + khtd_pkg::CNT_BITS'(1);
    end
    if (cmd.update) begin
      if (sel_a_r) begin
        a_nxt = parent;
      end else begin
        b_nxt = parent;
      end
      dist_nxt = dist_r + khtd_pkg::DIST_BITS'(1);
    end
    if (cmd.finish) begin
      dout_nxt = stat.path_mode ? khtd_pkg::DIST_BITS'(absdiff) : dist_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= khtd_pkg::BRANCH_RESET;
    end else begin
      k_r <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    dist_r  <= dist_nxt;
    dout_r  <= dout_nxt;
    x_r     <= x_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    sel_a_r <= sel_a_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/khtd_ctrl.sv =====
// ----------------------------------------------------------------------------
// khtd_ctrl
// Controller: sequences compare, divide and parent update steps and owns
// both channel handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module khtd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire khtd_pkg::dp_stat_t stat,
  output khtd_pkg::ctl_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       done;
  logic       out_free;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = ovalid_r;
  assign done      = stat.path_mode || stat.same;
  assign out_free  = !ovalid_r || out_ready;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    ovalid_nxt = ovalid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (done) begin
          // wait here until the output register frees up
          if (out_free) begin
            cmd.finish = 1'b1;
            ovalid_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          cmd.start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_CMP;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/kary_heap_tree_distance.sv =====
// with branching 0 or 1 the result is loaded from the compare state once the output register is free;
//   otherwise s parent steps run first, s = parent steps until the nodes meet (<= 94)
// each parent step is one pass of the bit-serial divider, one quotient bit per node bit,
//   plus one compare and one update step; the worst case is at k = 2
// one transaction at a time; the next is accepted in the cycle after finish
// reset: synchronous active low, clears control and sets branching to 2
// ----------------------------------------------------------------------------
// kary_heap_tree_distance
// Path length between two nodes of an implicit complete k-ary heap tree.
// ----------------------------------------------------------------------------
`default_nettype none

module kary_heap_tree_distance (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [khtd_pkg::BRANCH_BITS-1:0] cfg_wdata,
  khtd_in_if.sink                               in_ch,
  khtd_out_if.source                            out_ch
);

  khtd_pkg::ctl_cmd_t cmd;
  khtd_pkg::dp_stat_t stat;

  khtd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  khtd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .node_a    (in_ch.node_a),
    .node_b    (in_ch.node_b),
    .cmd       (cmd),
    .stat      (stat),
    .distance  (out_ch.distance)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/khtd_checker.sv =====
// ----------------------------------------------------------------------------
// khtd_checker
// Port-level assertions for the k-ary heap tree distance block, bound to
// the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module khtd_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             cfg_we,
  input wire logic [khtd_pkg::BRANCH_BITS-1:0] cfg_wdata,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [khtd_pkg::DIST_BITS-1:0]   out_distance
);

  // result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance))
    else $error("result dropped or changed while stalled");

  // one transaction in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in work");

  // a new result shows up only while the input side is closed
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a transaction in work");

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // branching changes only while the block is quiet
  a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> in_ready && !out_valid && !$isunknown(cfg_wdata))
    else $error("branching written while a transaction is in flight");

endmodule

bind kary_heap_tree_distance khtd_checker u_khtd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .cfg_we       (cfg_we),
  .cfg_wdata    (cfg_wdata),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_distance (out_ch.distance)
);

`default_nettype wire
